FILE: hdl/nzc_pkg.sv
package nzc_pkg;

    localparam int NIB_W  = 4;
    localparam int LANES  = 4;
    localparam int WORD_W = NIB_W * LANES;
    localparam int PEND_W = NIB_W * (LANES - 1);
    localparam int PCNT_W = 2;
    localparam int WCNT_W = 7;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic             nz;
        logic [NIB_W-1:0] nib;
    } lane_t;

    typedef struct packed {
        logic              full;
        logic [WORD_W-1:0] full_word;
        logic [PEND_W-1:0] pend;
        logic [PCNT_W-1:0] pend_cnt;
    } merge_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              eoa;
        logic              too_long;
    } out_item_t;

endpackage

FILE: hdl/nibble_zero_compaction.sv
// A full word from an accepted input transaction is pushed into the output queue.
// Throughput: one input word per cycle while no array is flushing and the queue is not full.
// After a final word with words still owed, the input stalls while the flush
// sequencer writes padded words into the two-entry queue, one per cycle when not full.
// Reset (rst_n, asynchronous, active low) clears pending nibbles, counters and the queue.
module nibble_zero_compaction
    import nzc_pkg::*;
#(
    parameter int MAX_WORDS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [WORD_W-1:0] packed_word,
    input  logic              final_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] out_word,
    output logic              end_of_array,
    output logic              too_long
);

    state_t            state_reg, state_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [WCNT_W-1:0] taken_reg, taken_next;
    logic [WCNT_W-1:0] given_reg, given_next;
    logic [WCNT_W-1:0] rem_reg, rem_next;
    logic              ovf_reg, ovf_next;

    lane_t [LANES-1:0] lanes;
    merge_t            mres;
    logic              fifo_full;
    logic              push;
    out_item_t         push_item;
    out_item_t         head;
    logic              accept;
    logic              drop;
    logic [WCNT_W-1:0] rem_calc;
    logic [WORD_W-1:0] pad_word;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        nzc_lane u_lane (
            .nib  (packed_word[WORD_W-1-NIB_W*i -: NIB_W]),
            .lane (lanes[i])
        );
    end

    nzc_merge u_merge (
        .lanes    (lanes),
        .pend     (pend_reg),
        .pend_cnt (pcnt_reg),
        .res      (mres)
    );

    nzc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_word     = head.word;
    assign end_of_array = head.eoa;
    assign too_long     = head.too_long;

    assign in_stall = (state_reg != ST_RUN) || fifo_full;
    assign accept   = in_valid && !in_stall;
    assign drop     = (taken_reg >= WCNT_W'(MAX_WORDS));
    // left-justify the partial word; an empty pending register gives zero padding
    assign pad_word = {{NIB_W{1'b0}}, pend_reg} << {(3'd4 - {1'b0, pcnt_reg}), 2'b00};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept && final_word && (rem_calc != '0))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!fifo_full && (rem_reg == WCNT_W'(1)))
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        pend_next  = pend_reg;
        pcnt_next  = pcnt_reg;
        taken_next = taken_reg;
        given_next = given_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        push       = 1'b0;
        push_item  = '0;
        rem_calc   = '0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    ovf_next = ovf_reg | drop;
                    if (!drop)
                    begin
                        taken_next = taken_reg + WCNT_W'(1);
                        pend_next  = mres.pend;
                        pcnt_next  = mres.pend_cnt;
                        if (mres.full)
                        begin
                            given_next = given_reg + WCNT_W'(1);
                            push       = 1'b1;
                        end
                    end
                    rem_calc           = taken_next - given_next;
                    push_item.word     = mres.full_word;
                    push_item.too_long = ovf_next;
                    push_item.eoa      = final_word && (rem_calc == '0);
                    if (final_word)
                    begin
                        rem_next = rem_calc;
                        if (rem_calc == '0)
                        begin
                            // nothing left to send: start the next array clean
                            pend_next  = '0;
                            pcnt_next  = '0;
                            taken_next = '0;
                            given_next = '0;
                            ovf_next   = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!fifo_full)
                begin
                    push               = 1'b1;
                    push_item.word     = pad_word;
                    push_item.too_long = ovf_reg;
                    push_item.eoa      = (rem_reg == WCNT_W'(1));
                    pend_next          = '0;
                    pcnt_next          = '0;
                    rem_next           = rem_reg - WCNT_W'(1);
                    if (rem_reg == WCNT_W'(1))
                    begin
                        taken_next = '0;
                        given_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            pend_reg  <= '0;
            pcnt_reg  <= '0;
            taken_reg <= '0;
            given_reg <= '0;
            rem_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            pcnt_reg  <= pcnt_next;
            taken_reg <= taken_next;
            given_reg <= given_next;
            rem_reg   <= rem_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: hdl/nzc_lane.sv
module nzc_lane
    import nzc_pkg::*;
(
    input  logic [NIB_W-1:0] nib,
    output lane_t            lane
);

    // zero the value of a dropped nibble so the merge can OR freely
    always_comb
    begin
        lane.nz  = (nib != '0);
        lane.nib = lane.nz ? nib : '0;
    end

endmodule

FILE: hdl/nzc_merge.sv
module nzc_merge
    import nzc_pkg::*;
(
    input  lane_t [LANES-1:0] lanes,
    input  logic [PEND_W-1:0] pend,
    input  logic [PCNT_W-1:0] pend_cnt,
    output merge_t            res
);

    localparam int COMB_W = PEND_W + WORD_W;

    logic [WORD_W-1:0] nk;
    logic [2:0]        k;
    logic [2:0]        total;
    logic [1:0]        rest;
    logic [COMB_W-1:0] comb;

    always_comb
    begin
        nk = '0;
        k  = '0;
        // lane 0 holds the first nibble; append survivors in order
        for (int i = 0; i < LANES; i++)
        begin
            if (lanes[i].nz)
            begin
                nk = {nk[WORD_W-NIB_W-1:0], lanes[i].nib};
                k  = k + 3'd1;
            end
        end
        total = {1'b0, pend_cnt} + k;
        comb  = ({{WORD_W{1'b0}}, pend} << {k, 2'b00}) | {{PEND_W{1'b0}}, nk};
        rest  = total[1:0];

        res = '0;
        if (total[2])
        begin
            res.full      = 1'b1;
            res.full_word = WORD_W'(comb >> {rest, 2'b00});
            res.pend      = comb[PEND_W-1:0] & ~({PEND_W{1'b1}} << {rest, 2'b00});
            res.pend_cnt  = rest;
        end
        else
        begin
            res.pend     = comb[PEND_W-1:0];
            res.pend_cnt = rest;
        end
    end

endmodule

FILE: hdl/nzc_fifo.sv
module nzc_fifo
    import nzc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t head
);

    out_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign pop       = out_valid && !out_stall;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
